// ===== design/mst_pkg.sv =====
// Shared types and constants of the Kruskal spanning tree unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package mst_pkg;

  // Fixed field widths
  localparam int unsigned VTX_W   = 4;
  localparam int unsigned COST_W  = 15;
  localparam int unsigned TOTAL_W = 19;
  localparam int unsigned CFG_W   = 5;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_EDGES_DEF    = 32;
  localparam int unsigned MAX_VERTICES_DEF = 16;

  // Reset value of the vertex count register
  localparam logic [CFG_W-1:0] VCOUNT_RST = 5'd5;

  // One stored graph edge
  typedef struct packed {
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
    logic [COST_W-1:0] cost;
  } edge_rec_t;

endpackage

// ===== design/mst_if.sv =====
// Valid/ready channel interfaces: edge input and tree result output.
// Depends on mst_pkg.
`timescale 1ns / 1ps

interface mst_edge_if;
  import mst_pkg::*;
  logic               valid;
  logic               ready;
  logic [VTX_W-1:0]   end_a;
  logic [VTX_W-1:0]   end_b;
  logic [COST_W-1:0]  weight;
  logic               final_edge;

  modport source (output valid, end_a, end_b, weight, final_edge, input ready);
  modport sink   (input valid, end_a, end_b, weight, final_edge, output ready);
endinterface

interface mst_result_if;
  import mst_pkg::*;
  logic               valid;
  logic               ready;
  logic [VTX_W-1:0]   tree_from;
  logic [VTX_W-1:0]   tree_to;
  logic [COST_W-1:0]  tree_cost;
  logic               edge_valid;
  logic [TOTAL_W-1:0] running_total;
  logic               spanning;
  logic               last_result;

  modport source (output valid, tree_from, tree_to, tree_cost, edge_valid,
                  running_total, spanning, last_result, input ready);
  modport sink   (input valid, tree_from, tree_to, tree_cost, edge_valid,
                  running_total, spanning, last_result, output ready);
endinterface

// ===== design/mst_edge_store.sv =====
// Edge memory: one write port, one read port with registered read data.
// Depends on mst_pkg for the edge record type.
`timescale 1ns / 1ps

module mst_edge_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  mst_pkg::edge_rec_t    wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output mst_pkg::edge_rec_t    rdata_o
);
  import mst_pkg::*;

  edge_rec_t mem_q [DEPTH];
  edge_rec_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mst_forest.sv =====
// Union-find parent links: one read address, one write port, bulk reset to self.
// No package dependencies.
`timescale 1ns / 1ps

module mst_forest #(
  parameter int unsigned N  = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o,
  output logic          is_root_o
);

  logic [AW-1:0] parent_q [N];

  // Every vertex points at itself after reset or clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        parent_q[i] <= AW'(i);
      end
    end else if (clear_i) begin
      for (int i = 0; i < N; i++) begin
        parent_q[i] <= AW'(i);
      end
    end else if (we_i) begin
      parent_q[waddr_i] <= wdata_i;
    end
  end

  // One link step of the root walk
  assign rdata_o   = parent_q[raddr_i];
  assign is_root_o = (parent_q[raddr_i] == raddr_i);

endmodule

// ===== design/minimum_spanning_tree_kruskal_unit.sv =====
// Kruskal spanning tree unit: top level with the run sequencer.
// Depends on mst_pkg, mst_if, mst_edge_store and mst_forest.
//
//  channel    | dir | handshake            | contents
//  -----------+-----+----------------------+---------------------------------------
//  edge_i     | in  | valid/ready          | end_a, end_b, weight, final_edge
//  result_o   | out | valid/ready          | tree edge, edge_valid, total, flags
//  cfg        | in  | cfg_we_i, no wait    | vertex_count
//
// Edges load into the store while the unit is idle. A run then repeats a pick
// pass over the E stored edges (a scan through the single memory read port,
// then a pick step) followed by two root walks, one step per vertex on the path,
// until the tree is complete or no edge is left; emission reads the store
// again, one edge at a time, in store order.
// Edge input is held off from the final edge until the last result is
// loaded into the output register. A stalled result only freezes emission.
// Reset is asynchronous and active low; the edge store needs no clearing.
`timescale 1ns / 1ps

module minimum_spanning_tree_kruskal_unit #(
  parameter int unsigned MAX_EDGES    = mst_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mst_pkg::CFG_W-1:0]  cfg_wdata_i,
  mst_edge_if.sink                   edge_i,
  mst_result_if.source               result_o
);
  import mst_pkg::*;

  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW = $clog2(MAX_VERTICES);

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_PICK      = 3'd2;
  localparam logic [2:0] S_WALK_A    = 3'd3;
  localparam logic [2:0] S_WALK_B    = 3'd4;
  localparam logic [2:0] S_EMIT_INIT = 3'd5;
  localparam logic [2:0] S_EMIT_RD   = 3'd6;
  localparam logic [2:0] S_EMIT_CHK  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CFG_W-1:0]     vcount_q, vcount_d;
  logic [CW-1:0]        loaded_q, loaded_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [EW-1:0]        rd_idx_q, rd_idx_d;
  logic                 found_q, found_d;
  logic [EW-1:0]        best_idx_q, best_idx_d;
  logic [COST_W-1:0]    best_cost_q, best_cost_d;
  logic [VTX_W-1:0]     best_va_q, best_va_d;
  logic [VTX_W-1:0]     best_vb_q, best_vb_d;
  logic [PW-1:0]        cur_q, cur_d;
  logic [PW-1:0]        root_a_q, root_a_d;
  logic [PW-1:0]        accepted_q, accepted_d;
  logic [PW-1:0]        emitted_q, emitted_d;
  logic [EW-1:0]        emit_idx_q, emit_idx_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [MAX_EDGES-1:0] taken_q, taken_d;
  logic [MAX_EDGES-1:0] refused_q, refused_d;

  // Output register
  logic                 res_valid_q, res_valid_d;
  logic [VTX_W-1:0]     res_from_q, res_from_d;
  logic [VTX_W-1:0]     res_to_q, res_to_d;
  logic [COST_W-1:0]    res_cost_q, res_cost_d;
  logic                 res_edge_q, res_edge_d;
  logic [TOTAL_W-1:0]   res_total_q, res_total_d;
  logic                 res_span_q, res_span_d;
  logic                 res_last_q, res_last_d;

  // Memory and forest hookup
  logic                 in_acc;
  logic                 mem_we, mem_re;
  logic [EW-1:0]        mem_raddr;
  edge_rec_t            mem_wdata, mem_rdata;
  logic                 fr_clear, fr_we;
  logic [PW-1:0]        fr_parent;
  logic                 fr_is_root;
  logic                 issue;
  logic                 out_free;
  logic [PW-1:0]        needed;
  logic                 best_oor;
  logic [TOTAL_W-1:0]   sum_next;

  assign in_acc       = edge_i.valid && edge_i.ready;
  assign edge_i.ready = (state_q == S_IDLE);
  assign out_free     = !res_valid_q || result_o.ready;

  // Tree edge count from the clamped vertex count
  assign needed = (vcount_q == '0) ? '0 :
                  (32'(vcount_q) >= MAX_VERTICES) ? PW'(MAX_VERTICES - 1) :
                  PW'(vcount_q - 5'd1);

  assign best_oor = (32'(best_va_q) >= MAX_VERTICES) || (32'(best_vb_q) >= MAX_VERTICES);

  // Edge store write on load, read for scan and emission
  assign mem_we          = in_acc && (loaded_q < CW'(MAX_EDGES));
  assign mem_wdata.va    = edge_i.end_a;
  assign mem_wdata.vb    = edge_i.end_b;
  assign mem_wdata.cost  = edge_i.weight;
  assign issue           = (state_q == S_SCAN) && (scan_q < loaded_q);
  assign mem_re          = issue || (state_q == S_EMIT_RD);
  assign mem_raddr       = (state_q == S_SCAN) ? scan_q[EW-1:0] : emit_idx_q;
  assign fr_clear        = in_acc && edge_i.final_edge;
  assign fr_we           = (state_q == S_WALK_B) && fr_is_root && (cur_q != root_a_q);
  assign sum_next        = total_q + TOTAL_W'(mem_rdata.cost);

  mst_edge_store #(
    .DEPTH (MAX_EDGES),
    .AW    (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (loaded_q[EW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mst_forest #(
    .N  (MAX_VERTICES),
    .AW (PW)
  ) u_forest (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (fr_clear),
    .we_i      (fr_we),
    .waddr_i   (root_a_q),
    .wdata_i   (cur_q),
    .raddr_i   (cur_q),
    .rdata_o   (fr_parent),
    .is_root_o (fr_is_root)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    loaded_d    = loaded_q;
    scan_d      = scan_q;
    rd_vld_d    = issue;
    rd_idx_d    = scan_q[EW-1:0];
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_cost_d = best_cost_q;
    best_va_d   = best_va_q;
    best_vb_d   = best_vb_q;
    cur_d       = cur_q;
    root_a_d    = root_a_q;
    accepted_d  = accepted_q;
    emitted_d   = emitted_q;
    emit_idx_d  = emit_idx_q;
    total_d     = total_q;
    taken_d     = taken_q;
    refused_d   = refused_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_from_d  = res_from_q;
    res_to_d    = res_to_q;
    res_cost_d  = res_cost_q;
    res_edge_d  = res_edge_q;
    res_total_d = res_total_q;
    res_span_d  = res_span_q;
    res_last_d  = res_last_q;

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
    end

    case (state_q)
      // Load edges; the final one starts a run
      S_IDLE: begin
        if (in_acc) begin
          if (mem_we) begin
            loaded_d = loaded_q + 1'b1;
          end
          if (edge_i.final_edge) begin
            taken_d    = '0;
            refused_d  = '0;
            accepted_d = '0;
            scan_d     = '0;
            found_d    = 1'b0;
            state_d    = (needed == '0) ? S_EMIT_INIT : S_SCAN;
          end
        end
      end

      // Cheapest unmarked edge, first index wins ties
      S_SCAN: begin
        if (issue) begin
          scan_d = scan_q + 1'b1;
        end
        if (rd_vld_q && !(taken_q[rd_idx_q] || refused_q[rd_idx_q]) &&
            (!found_q || (mem_rdata.cost < best_cost_q))) begin
          found_d     = 1'b1;
          best_idx_d  = rd_idx_q;
          best_cost_d = mem_rdata.cost;
          best_va_d   = mem_rdata.va;
          best_vb_d   = mem_rdata.vb;
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        if (!found_q) begin
          state_d = S_EMIT_INIT;
        end else if (best_oor) begin
          refused_d[best_idx_q] = 1'b1;
          scan_d  = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          cur_d   = PW'(best_va_q);
          state_d = S_WALK_A;
        end
      end

      // Root of the first endpoint
      S_WALK_A: begin
        if (fr_is_root) begin
          root_a_d = cur_q;
          cur_d    = PW'(best_vb_q);
          state_d  = S_WALK_B;
        end else begin
          cur_d = fr_parent;
        end
      end

      // Root of the second endpoint, then accept or reject
      S_WALK_B: begin
        if (fr_is_root) begin
          scan_d  = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
          if (cur_q == root_a_q) begin
            refused_d[best_idx_q] = 1'b1;
          end else begin
            taken_d[best_idx_q] = 1'b1;
            accepted_d          = accepted_q + 1'b1;
            if ((accepted_q + 1'b1) == needed) begin
              state_d = S_EMIT_INIT;
            end
          end
        end else begin
          cur_d = fr_parent;
        end
      end

      S_EMIT_INIT: begin
        loaded_d   = '0;
        emitted_d  = '0;
        total_d    = '0;
        emit_idx_d = '0;
        if (accepted_q != '0) begin
          state_d = S_EMIT_RD;
        end else if (out_free) begin
          // Empty tree: one result with no edge
          res_valid_d = 1'b1;
          res_from_d  = '0;
          res_to_d    = '0;
          res_cost_d  = '0;
          res_edge_d  = 1'b0;
          res_total_d = '0;
          res_span_d  = (accepted_q == needed);
          res_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        state_d = S_EMIT_CHK;
      end

      // Emit accepted edges in store order
      S_EMIT_CHK: begin
        if (taken_q[emit_idx_q]) begin
          if (out_free) begin
            res_valid_d = 1'b1;
            res_from_d  = mem_rdata.va;
            res_to_d    = mem_rdata.vb;
            res_cost_d  = mem_rdata.cost;
            res_edge_d  = 1'b1;
            res_total_d = sum_next;
            res_span_d  = (accepted_q == needed);
            res_last_d  = ((emitted_q + 1'b1) == accepted_q);
            total_d     = sum_next;
            emitted_d   = emitted_q + 1'b1;
            emit_idx_d  = emit_idx_q + 1'b1;
            state_d     = ((emitted_q + 1'b1) == accepted_q) ? S_IDLE : S_EMIT_RD;
          end
        end else begin
          emit_idx_d = emit_idx_q + 1'b1;
          state_d    = S_EMIT_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= VCOUNT_RST;
      loaded_q    <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      accepted_q  <= '0;
      emitted_q   <= '0;
      emit_idx_q  <= '0;
      taken_q     <= '0;
      refused_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      loaded_q    <= loaded_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      accepted_q  <= accepted_d;
      emitted_q   <= emitted_d;
      emit_idx_q  <= emit_idx_d;
      taken_q     <= taken_d;
      refused_q   <= refused_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_cost_q <= best_cost_d;
    best_va_q   <= best_va_d;
    best_vb_q   <= best_vb_d;
    cur_q       <= cur_d;
    root_a_q    <= root_a_d;
    total_q     <= total_d;
    res_from_q  <= res_from_d;
    res_to_q    <= res_to_d;
    res_cost_q  <= res_cost_d;
    res_edge_q  <= res_edge_d;
    res_total_q <= res_total_d;
    res_span_q  <= res_span_d;
    res_last_q  <= res_last_d;
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.tree_from     = res_from_q;
  assign result_o.tree_to       = res_to_q;
  assign result_o.tree_cost     = res_cost_q;
  assign result_o.edge_valid    = res_edge_q;
  assign result_o.running_total = res_total_q;
  assign result_o.spanning      = res_span_q;
  assign result_o.last_result   = res_last_q;

endmodule

// ===== design/mst_checker.sv =====
// Port-level checks of the Kruskal spanning tree unit, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module mst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_final_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_edge_valid_i,
  input logic out_last_i
);

  // A non-final edge leaves the block ready for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_final_i |=> in_ready_i)
    else $error("ready dropped after a non-final edge");

  // The final edge starts a run that holds off new edges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("edge taken right after the final edge");

  // A result without an edge is the only result of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_edge_valid_i |-> out_last_i)
    else $error("empty result not marked last");

  // A pending result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind minimum_spanning_tree_kruskal_unit mst_checker u_mst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (edge_i.valid),
  .in_ready_i       (edge_i.ready),
  .in_final_i       (edge_i.final_edge),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .out_edge_valid_i (result_o.edge_valid),
  .out_last_i       (result_o.last_result)
);

// ===== verif/testbench.sv =====
// Self-checking bench for the Kruskal spanning tree unit: queued edge graphs,
// random valid/ready gaps, and a built-in forest predictor compared per result.
// Depends on mst_pkg, mst_if and the minimum_spanning_tree_kruskal_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import mst_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_EDGES_DEF;
  localparam int unsigned VTX_DEPTH   = MAX_VERTICES_DEF;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          TAIL_CYCLES = 50;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [COST_W-1:0] COST_TOP = '1;

  typedef enum logic [1:0] {
    MARK_OPEN,
    MARK_IN_TREE,
    MARK_DROPPED
  } edge_mark_e;

  typedef struct packed {
    edge_rec_t rec;
    logic      fin;
  } edge_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]   tree_from;
    logic [VTX_W-1:0]   tree_to;
    logic [COST_W-1:0]  tree_cost;
    logic               edge_valid;
    logic [TOTAL_W-1:0] running_total;
    logic               spanning;
    logic               last_result;
  } tree_edge_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  mst_edge_if   edge_ch ();
  mst_result_if res_ch ();

  minimum_spanning_tree_kruskal_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_ch),
    .result_o    (res_ch)
  );

  // Stimulus and expectation stores
  edge_item_t edge_pend_q[$];
  tree_edge_t tree_q[$];
  int         errors = 0;
  logic       edge_took = 1'b0;
  bit         calm = 1'b0;
  bit         stall_phase = 1'b0;

  // Receiver hold-off, watchdog count and per-phase vertex counts
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;
  int         phase_vc [7] = '{16, 3, 31, 8, 2, 12, 5};

  // Predictor state: stored graph, marks and union-find forest
  edge_rec_t        graph_edges [STORE_DEPTH];
  edge_mark_e       edge_marks  [STORE_DEPTH];
  logic [VTX_W-1:0] forest_parent [VTX_DEPTH];
  int unsigned      loaded_cnt = 0;
  logic [CFG_W-1:0] vcount_reg = VCOUNT_RST;

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Follow parent links up to the root, bounded by the vertex depth
  function automatic logic [VTX_W-1:0] find_root(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] cur;
    bit               done;
    cur  = v;
    done = 1'b0;
    for (int n = 0; n < VTX_DEPTH; n++) begin
      if (!done) begin
        if (forest_parent[cur] == cur) done = 1'b1;
        else cur = forest_parent[cur];
      end
    end
    return cur;
  endfunction

  // Store one accepted edge; on the last edge build the tree and queue results
  task automatic predict_tree(input edge_item_t it);
    int unsigned         vc, need, taken, best;
    bit                  found, exhausted, have_prev;
    logic [VTX_W-1:0]    ra, rb;
    logic [TOTAL_W-1:0]  total;
    logic                span;
    tree_edge_t          prev;
    if (loaded_cnt < STORE_DEPTH) begin
      graph_edges[loaded_cnt] = it.rec;
      edge_marks[loaded_cnt]  = MARK_OPEN;
      loaded_cnt++;
    end
    if (!it.fin) return;

    vc = vcount_reg;
    if (vc < 1) vc = 1;
    if (vc > VTX_DEPTH) vc = VTX_DEPTH;
    need = vc - 1;
    for (int i = 0; i < VTX_DEPTH; i++) forest_parent[i] = i[VTX_W-1:0];
    for (int i = 0; i < loaded_cnt; i++) edge_marks[i] = MARK_OPEN;
    taken     = 0;
    exhausted = 1'b0;

    // Cheapest open edge each pass, lowest index on ties
    while (taken < need && !exhausted) begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < loaded_cnt; i++) begin
        if (edge_marks[i] == MARK_OPEN &&
            (!found || graph_edges[i].cost < graph_edges[best].cost)) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        exhausted = 1'b1;
      end else begin
        ra = find_root(graph_edges[best].va);
        rb = find_root(graph_edges[best].vb);
        if (ra == rb) begin
          edge_marks[best] = MARK_DROPPED;
        end else begin
          edge_marks[best]  = MARK_IN_TREE;
          forest_parent[ra] = rb;
          taken++;
        end
      end
    end

    // Emit tree edges in store order; the last one carries the end flag
    span      = (taken == need);
    total     = '0;
    have_prev = 1'b0;
    for (int i = 0; i < loaded_cnt; i++) begin
      if (edge_marks[i] == MARK_IN_TREE) begin
        if (have_prev) tree_q.push_back(prev);
        total = total + graph_edges[i].cost;
        prev  = '{tree_from: graph_edges[i].va, tree_to: graph_edges[i].vb,
                  tree_cost: graph_edges[i].cost, edge_valid: 1'b1,
                  running_total: total, spanning: span, last_result: 1'b0};
        have_prev = 1'b1;
      end
    end
    if (have_prev) begin
      prev.last_result = 1'b1;
      tree_q.push_back(prev);
    end else begin
      tree_q.push_back('{tree_from: '0, tree_to: '0, tree_cost: '0, edge_valid: 1'b0,
                         running_total: '0, spanning: span, last_result: 1'b1});
    end
    loaded_cnt = 0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: config writes, accepted edges and accepted results at the rising edge
  always @(posedge clk_i) begin : monitor
    tree_edge_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) vcount_reg = cfg_wdata_i;
      edge_took <= edge_ch.valid && edge_ch.ready;
      if (edge_ch.valid && edge_ch.ready)
        predict_tree('{rec: '{va: edge_ch.end_a, vb: edge_ch.end_b, cost: edge_ch.weight},
                       fin: edge_ch.final_edge});
      if (res_ch.valid && res_ch.ready) begin
        got = '{tree_from: res_ch.tree_from, tree_to: res_ch.tree_to,
                tree_cost: res_ch.tree_cost, edge_valid: res_ch.edge_valid,
                running_total: res_ch.running_total, spanning: res_ch.spanning,
                last_result: res_ch.last_result};
        if (tree_q.size() == 0) begin
          $display("%0t ERROR unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = tree_q.pop_front();
          check_field("tree_from", want.tree_from, got.tree_from);
          check_field("tree_to", want.tree_to, got.tree_to);
          check_field("tree_cost", want.tree_cost, got.tree_cost);
          check_field("edge_valid", want.edge_valid, got.edge_valid);
          check_field("running_total", want.running_total, got.running_total);
          check_field("spanning", want.spanning, got.spanning);
          check_field("last_result", want.last_result, got.last_result);
        end
      end
    end
  end

  // Edge driver: holds a transaction until accepted, random gaps otherwise
  always @(negedge clk_i) begin : edge_driver
    logic       next_valid;
    edge_item_t it;
    if (rst_ni && !(edge_ch.valid && !edge_took)) begin
      next_valid = 1'b0;
      if (edge_pend_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        it                 = edge_pend_q.pop_front();
        edge_ch.end_a      <= it.rec.va;
        edge_ch.end_b      <= it.rec.vb;
        edge_ch.weight     <= it.rec.cost;
        edge_ch.final_edge <= it.fin;
        next_valid         = 1'b1;
      end
      edge_ch.valid <= next_valid;
    end
  end

  // Result receiver: random stalls, plus one long hold-off in the stall phase
  always @(negedge clk_i) begin : result_receiver
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_phase && !hold_done && res_ch.valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ERROR watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_edge(input int a, input int b, input int w, input bit fin);
    edge_item_t it;
    it.rec.va   = a[VTX_W-1:0];
    it.rec.vb   = b[VTX_W-1:0];
    it.rec.cost = w[COST_W-1:0];
    it.fin      = fin;
    edge_pend_q.push_back(it);
  endtask

  // Random graph of the given number of edges over mostly in-range vertices
  task automatic queue_graph(input int n, input int span, input int wmax);
    int a, b, w, r;
    for (int k = 0; k < n; k++) begin
      a = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(span - 1);
      b = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(span - 1);
      r = $urandom_range(19);
      if (r == 0) w = COST_TOP;
      else if (r == 1) w = 0;
      else w = $urandom_range(wmax);
      push_edge(a, b, w, k == n - 1);
    end
  endtask

  // Wait until all queued edges went in and every result came out;
  // checked at the rising edge, where driver and monitor updates have settled
  task automatic settle();
    while (edge_pend_q.size() != 0 || edge_ch.valid || tree_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_vcount(input int v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int vc, input int n_items);
    int eff, sent, n, wmax;
    eff  = (vc < 1) ? 1 : ((vc > VTX_DEPTH) ? VTX_DEPTH : vc);
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(15))
        0:       n = $urandom_range(33, 36);
        1, 2:    n = $urandom_range(1, 3);
        default: n = $urandom_range(eff, 2 * eff + 2);
      endcase
      if (n > 30 && n < 33) n = 30;
      wmax = ($urandom_range(3) == 0) ? 3 : 32766;
      queue_graph(n, eff, wmax);
      sent += n;
    end
    settle();
  endtask

  // Sequencer: reset, directed graphs, then random phases over several counts
  initial begin : sequencer
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    edge_ch.valid      = 1'b0;
    edge_ch.end_a      = '0;
    edge_ch.end_b      = '0;
    edge_ch.weight     = '0;
    edge_ch.final_edge = 1'b0;
    res_ch.ready       = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset count: self loop only, then a full tree with ties and cost extremes,
    // then a disconnected graph with a duplicate and an out-of-range vertex
    push_edge(0, 0, 100, 1);
    push_edge(0, 1, COST_TOP, 0);
    push_edge(1, 2, 0, 0);
    push_edge(2, 3, 0, 0);
    push_edge(3, 4, COST_TOP, 1);
    push_edge(0, 15, 5, 0);
    push_edge(1, 2, 5, 0);
    push_edge(2, 1, 3, 0);
    push_edge(3, 3, 9, 1);
    settle();

    // One vertex: the tree needs no edge
    write_vcount(1);
    push_edge(0, 1, 7, 1);
    settle();

    // Zero counts as one vertex
    write_vcount(0);
    push_edge(5, 10, 12345, 1);
    settle();

    // Above the maximum counts as sixteen: full-width chain
    write_vcount(31);
    for (int k = 0; k < 15; k++)
      push_edge(15 - k, 14 - k, (k == 14) ? COST_TOP : (k * 2341) % 32767, k == 14);
    settle();

    for (int p = 0; p < 7; p++) begin
      write_vcount(phase_vc[p]);
      calm        = (p == 2);
      stall_phase = (p == 4);
      random_phase(phase_vc[p], 50);
    end
    calm        = 1'b0;
    stall_phase = 1'b0;

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
design/mst_pkg.sv
design/mst_if.sv
design/mst_edge_store.sv
design/mst_forest.sv
design/minimum_spanning_tree_kruskal_unit.sv
design/mst_checker.sv
verif/testbench.sv
